>>> hw/rtl/onset_tempo_tracker_assert.svh
// Assertion macros for the onset tempo tracker.
// Used by the controller and datapath modules; no other dependencies.
`ifndef ONSET_TEMPO_TRACKER_ASSERT_SVH
`define ONSET_TEMPO_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset
`define OTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included
`define OTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTT_ASSERT(lbl, prop, msg)
`define OTT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/ott_pkg.sv
// Shared types and constants of the onset tempo tracker.
// No dependencies; imported by every RTL module.
package ott_pkg;

    localparam int unsigned DATA_W         = 32;
    localparam int unsigned TEMPO_W        = 16;
    localparam int unsigned MIN_ONSET_FILL = 5;
    localparam int unsigned APB_ADDR_W     = 5;
    localparam int unsigned BPM_PROD_W     = 40;

    localparam logic [TEMPO_W-1:0]    TEMPO_RESET   = 16'h7800;
    localparam logic [BPM_PROD_W-1:0] BPM_NUMERATOR = 40'd30000;
    // 30000 in Q8.8
    localparam logic [DATA_W-1:0]     BPM_DIVIDEND  = 32'd7680000;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_ONSET_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_MIN_BEAT_GAP     = 3'd1;
    localparam logic [2:0] REG_BEATS_PER_UPDATE = 3'd2;
    localparam logic [2:0] REG_MIN_BPM          = 3'd3;
    localparam logic [2:0] REG_MAX_BPM          = 3'd4;

    typedef struct packed {
        logic [31:0] onset_threshold;
        logic [15:0] min_beat_gap_ms;
        logic [3:0]  beats_per_update;
        logic [7:0]  min_bpm;
        logic [7:0]  max_bpm;
    } cfg_t;

    // Datapath operation, one per controller state
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_WIN_UPD,
        OP_THR_MUL,
        OP_THR_CMP,
        OP_BEAT,
        OP_IV_FIRST,
        OP_IV_PRV,
        OP_IV_RD,
        OP_IV_SUB,
        OP_IV_MUL,
        OP_IV_CHK,
        OP_DIV,
        OP_INS_RD,
        OP_INS_CMP,
        OP_IV_NEXT,
        OP_MED_RD,
        OP_MED_LO,
        OP_MED_CALC,
        OP_HIST_RD,
        OP_HIST_ACC,
        OP_AVG_GO,
        OP_AVG_DIV,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic in_take;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic beat_det;
        logic est_due;
        logic bt_enough;
        logic iv_ok;
        logic iv_more;
        logic j_zero;
        logic shift_go;
        logic n_zero;
        logic hist_more;
        logic div_done;
    } sts_t;

endpackage

>>> hw/rtl/onset_tempo_tracker.sv
// Onset tempo tracker top level: APB register file, controller and datapath.
// Depends on ott_pkg, ott_ctrl and ott_dp.
//  Input channel (in_valid / in_stall) carries one frame: onset_value (Q16.16)
//  and frame_time_ms. Each accepted frame yields exactly one output
//  transaction (out_valid / out_stall) with the smoothed tempo (Q8.8) and a
//  beat flag.
//  A frame that is not a beat passes the window update and the threshold
//  multiply and compare before the output state; a beat adds the beat step.
//  A tempo update then reads the first beat time and, for each stored
//  interval, reads, subtracts, multiplies and checks it; an accepted interval
//  goes through the shared radix-2 divider and the insertion sort, whose scan
//  stops at a value that is not larger. Then come the median steps, a read
//  and accumulate per history entry and the weighted mean in the divider.
//  One frame is in flight at a time; in_stall is low only while idle.
//  The result sits in an output register, so the next frame is accepted
//  while the previous result waits under out_stall. Reset clears fill
//  counts and state and sets the tempo to 120.0 BPM; no clearing pass is
//  needed. Registers must be written only while idle; the block does not check.
module onset_tempo_tracker
#(
    parameter int unsigned ONSET_WINDOW        = 20,
    parameter int unsigned BEAT_TIME_DEPTH     = 16,
    parameter int unsigned TEMPO_HISTORY_DEPTH = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ott_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ott_pkg::DATA_W-1:0]       onset_value,
    input  logic [ott_pkg::DATA_W-1:0]       frame_time_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [ott_pkg::TEMPO_W-1:0]      tempo_bpm,
    output logic                             beat
);
    import ott_pkg::*;

    cfg_t       cfg_reg;
    cmd_t       cmd;
    sts_t       sts;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.onset_threshold  <= 32'd6554;
            cfg_reg.min_beat_gap_ms  <= 16'd200;
            cfg_reg.beats_per_update <= 4'd10;
            cfg_reg.min_bpm          <= 8'd60;
            cfg_reg.max_bpm          <= 8'd200;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ONSET_THRESHOLD:  cfg_reg.onset_threshold  <= pwdata;
                REG_MIN_BEAT_GAP:     cfg_reg.min_beat_gap_ms  <= pwdata[15:0];
                REG_BEATS_PER_UPDATE: cfg_reg.beats_per_update <= pwdata[3:0];
                REG_MIN_BPM:          cfg_reg.min_bpm          <= pwdata[7:0];
                REG_MAX_BPM:          cfg_reg.max_bpm          <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_ONSET_THRESHOLD:  prdata = cfg_reg.onset_threshold;
            REG_MIN_BEAT_GAP:     prdata = {16'd0, cfg_reg.min_beat_gap_ms};
            REG_BEATS_PER_UPDATE: prdata = {28'd0, cfg_reg.beats_per_update};
            REG_MIN_BPM:          prdata = {24'd0, cfg_reg.min_bpm};
            REG_MAX_BPM:          prdata = {24'd0, cfg_reg.max_bpm};
            default:              prdata = '0;
        endcase
    end

    ott_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ott_dp
    #(
        .ONSET_WINDOW        (ONSET_WINDOW),
        .BEAT_TIME_DEPTH     (BEAT_TIME_DEPTH),
        .TEMPO_HISTORY_DEPTH (TEMPO_HISTORY_DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .onset_value   (onset_value),
        .frame_time_ms (frame_time_ms),
        .tempo_bpm     (tempo_bpm),
        .beat          (beat)
    );

endmodule

>>> hw/rtl/ott_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ott_pkg for the data width.
module ott_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ott_pkg::DATA_W-1:0] dividend,
    input  logic [ott_pkg::DATA_W-1:0] divisor,
    output logic [ott_pkg::DATA_W-1:0] quotient,
    output logic                      done
);
    import ott_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dsr_reg, dsr_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // One shift-subtract step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> hw/rtl/ott_ctrl.sv
// Sequencing state machine of the onset tempo tracker.
// Depends on ott_pkg and onset_tempo_tracker_assert.svh; drives ott_dp.
`include "onset_tempo_tracker_assert.svh"
module ott_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output ott_pkg::cmd_t cmd,
    input  ott_pkg::sts_t sts
);
    import ott_pkg::*;

    typedef enum logic [22:0] {
        ST_IDLE     = 23'd1 << 0,
        ST_WIN_UPD  = 23'd1 << 1,
        ST_THR_MUL  = 23'd1 << 2,
        ST_THR_CMP  = 23'd1 << 3,
        ST_BEAT     = 23'd1 << 4,
        ST_IV_FIRST = 23'd1 << 5,
        ST_IV_PRV   = 23'd1 << 6,
        ST_IV_RD    = 23'd1 << 7,
        ST_IV_SUB   = 23'd1 << 8,
        ST_IV_MUL   = 23'd1 << 9,
        ST_IV_CHK   = 23'd1 << 10,
        ST_DIV      = 23'd1 << 11,
        ST_INS_RD   = 23'd1 << 12,
        ST_INS_CMP  = 23'd1 << 13,
        ST_IV_NEXT  = 23'd1 << 14,
        ST_MED_RD   = 23'd1 << 15,
        ST_MED_LO   = 23'd1 << 16,
        ST_MED_CALC = 23'd1 << 17,
        ST_HIST_RD  = 23'd1 << 18,
        ST_HIST_ACC = 23'd1 << 19,
        ST_AVG_GO   = 23'd1 << 20,
        ST_AVG_DIV  = 23'd1 << 21,
        ST_OUT      = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;
    op_t    op;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept) state_next = ST_WIN_UPD;
            ST_WIN_UPD:  state_next = ST_THR_MUL;
            ST_THR_MUL:  state_next = ST_THR_CMP;
            ST_THR_CMP:  state_next = sts.beat_det ? ST_BEAT : ST_OUT;
            ST_BEAT:     state_next = (sts.est_due && sts.bt_enough) ? ST_IV_FIRST : ST_OUT;
            ST_IV_FIRST: state_next = ST_IV_PRV;
            ST_IV_PRV:   state_next = ST_IV_SUB;
            ST_IV_RD:    state_next = ST_IV_SUB;
            ST_IV_SUB:   state_next = ST_IV_MUL;
            ST_IV_MUL:   state_next = ST_IV_CHK;
            ST_IV_CHK:   state_next = sts.iv_ok ? ST_DIV : ST_IV_NEXT;
            ST_DIV:      if (sts.div_done) state_next = ST_INS_RD;
            ST_INS_RD:   state_next = sts.j_zero ? ST_IV_NEXT : ST_INS_CMP;
            ST_INS_CMP:  state_next = sts.shift_go ? ST_INS_RD : ST_IV_NEXT;
            ST_IV_NEXT:  state_next = sts.iv_more ? ST_IV_RD : ST_MED_RD;
            ST_MED_RD:   state_next = sts.n_zero ? ST_OUT : ST_MED_LO;
            ST_MED_LO:   state_next = ST_MED_CALC;
            ST_MED_CALC: state_next = ST_HIST_RD;
            ST_HIST_RD:  state_next = ST_HIST_ACC;
            ST_HIST_ACC: state_next = sts.hist_more ? ST_HIST_RD : ST_AVG_GO;
            ST_AVG_GO:   state_next = ST_AVG_DIV;
            ST_AVG_DIV:  if (sts.div_done) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Operation for the datapath
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:     op = OP_IDLE;
            ST_WIN_UPD:  op = OP_WIN_UPD;
            ST_THR_MUL:  op = OP_THR_MUL;
            ST_THR_CMP:  op = OP_THR_CMP;
            ST_BEAT:     op = OP_BEAT;
            ST_IV_FIRST: op = OP_IV_FIRST;
            ST_IV_PRV:   op = OP_IV_PRV;
            ST_IV_RD:    op = OP_IV_RD;
            ST_IV_SUB:   op = OP_IV_SUB;
            ST_IV_MUL:   op = OP_IV_MUL;
            ST_IV_CHK:   op = OP_IV_CHK;
            ST_DIV:      op = OP_DIV;
            ST_INS_RD:   op = OP_INS_RD;
            ST_INS_CMP:  op = OP_INS_CMP;
            ST_IV_NEXT:  op = OP_IV_NEXT;
            ST_MED_RD:   op = OP_MED_RD;
            ST_MED_LO:   op = OP_MED_LO;
            ST_MED_CALC: op = OP_MED_CALC;
            ST_HIST_RD:  op = OP_HIST_RD;
            ST_HIST_ACC: op = OP_HIST_ACC;
            ST_AVG_GO:   op = OP_AVG_GO;
            ST_AVG_DIV:  op = OP_AVG_DIV;
            ST_OUT:      op = OP_OUT;
            default:     op = OP_IDLE;
        endcase
    end

    assign cmd.op       = op;
    assign cmd.in_take  = accept;
    assign cmd.out_load = (state_reg == ST_OUT) && out_free;

    // Output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OTT_ASSERT(a_accept_starts, accept |=> state_reg == ST_WIN_UPD, "accept did not start item")
    `OTT_ASSERT(a_div_to_insert, (state_reg == ST_DIV) && sts.div_done |=> state_reg == ST_INS_RD,
        "divider result not inserted")
    `OTT_ASSERT(a_out_loads, (state_reg == ST_OUT) && !out_valid_reg |=> out_valid_reg,
        "free output register not loaded")

endmodule

>>> hw/rtl/ott_dp.sv
// Datapath of the onset tempo tracker: stores, arithmetic and shared divider.
// Depends on ott_pkg, ott_div and onset_tempo_tracker_assert.svh.
`include "onset_tempo_tracker_assert.svh"
module ott_dp
#(
    parameter int unsigned ONSET_WINDOW        = 20,
    parameter int unsigned BEAT_TIME_DEPTH     = 16,
    parameter int unsigned TEMPO_HISTORY_DEPTH = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ott_pkg::cfg_t                cfg,
    input  ott_pkg::cmd_t                cmd,
    output ott_pkg::sts_t                sts,
    input  logic [ott_pkg::DATA_W-1:0]   onset_value,
    input  logic [ott_pkg::DATA_W-1:0]   frame_time_ms,
    output logic [ott_pkg::TEMPO_W-1:0]  tempo_bpm,
    output logic                         beat
);
    import ott_pkg::*;

    localparam int unsigned WIN_AW = $clog2(ONSET_WINDOW);
    localparam int unsigned WIN_CW = $clog2(ONSET_WINDOW + 1);
    localparam int unsigned SUM_W  = DATA_W + WIN_CW;
    localparam int unsigned RHS_W  = SUM_W + 2;
    localparam int unsigned BT_AW  = $clog2(BEAT_TIME_DEPTH);
    localparam int unsigned BT_CW  = $clog2(BEAT_TIME_DEPTH + 1);
    localparam int unsigned H_AW   = (TEMPO_HISTORY_DEPTH > 1) ? $clog2(TEMPO_HISTORY_DEPTH) : 1;
    localparam int unsigned H_CW   = $clog2(TEMPO_HISTORY_DEPTH + 1);
    localparam int unsigned WGT_W  = $clog2(TEMPO_HISTORY_DEPTH + 2);

    // Control state
    logic [WIN_CW-1:0]  win_fill_reg;
    logic [WIN_AW-1:0]  win_head_reg;
    logic [SUM_W-1:0]   win_sum_reg;
    logic [DATA_W-1:0]  prev_onset_reg;
    logic [DATA_W-1:0]  last_beat_reg;
    logic [BT_CW-1:0]   bt_fill_reg;
    logic [BT_AW-1:0]   bt_head_reg;
    logic [3:0]         since_reg;
    logic [H_CW-1:0]    h_fill_reg;
    logic [H_AW-1:0]    h_head_reg;
    logic [TEMPO_W-1:0] tempo_reg;

    // Working registers
    logic [DATA_W-1:0]     v_reg, now_reg;
    logic [SUM_W-1:0]      lhs_reg, thrf_reg;
    logic                  beat_reg;
    logic [DATA_W-1:0]     ivprev_reg, iv_reg;
    logic [BPM_PROD_W-1:0] lo_reg, hi_reg;
    logic [TEMPO_W-1:0]    q_reg, mhi_reg;
    logic [BT_CW-1:0]      bt_idx_reg, n_reg, j_reg;
    logic [H_CW-1:0]       h_idx_reg;
    logic [DATA_W-1:0]     acc_reg, wsum_reg;
    logic [TEMPO_W-1:0]    out_tempo_reg;
    logic                  out_beat_reg;

    // Memories and their registered read data
    logic [DATA_W-1:0]  win_mem  [ONSET_WINDOW];
    logic [DATA_W-1:0]  bt_mem   [BEAT_TIME_DEPTH];
    logic [TEMPO_W-1:0] vals_mem [BEAT_TIME_DEPTH];
    logic [TEMPO_W-1:0] h_mem    [TEMPO_HISTORY_DEPTH];
    logic [DATA_W-1:0]  win_rd_reg, bt_rd_reg;
    logic [TEMPO_W-1:0] vals_rd_reg, h_rd_reg;

    // Divider
    logic              div_start;
    logic [DATA_W-1:0] div_dividend, div_divisor, div_quotient;
    logic              div_done;

    // Combinational helpers
    logic                 win_full, bt_full, h_full;
    logic [WIN_AW-1:0]    win_wa;
    logic [BT_AW-1:0]     bt_wa, bt_ra;
    logic [BT_CW-1:0]     bt_log;
    logic [BT_AW:0]       bt_sum;
    logic [H_AW-1:0]      h_wa, h_ra;
    logic [H_AW:0]        h_sum;
    logic [BT_CW-1:0]     vals_ra_full;
    logic [BT_AW-1:0]     vals_wa;
    logic                 vals_we;
    logic [TEMPO_W-1:0]   vals_wd;
    logic [RHS_W-1:0]     rhs;
    logic                 fill_ok, gap_ok, beat_det;
    logic [3:0]           since_inc;
    logic                 iv_ok;
    logic [TEMPO_W-1:0]   med;
    logic [TEMPO_W:0]     med_sum;
    logic [WGT_W-1:0]     weight;
    logic [BT_CW-1:0]     bt_idx_inc;
    logic [H_CW-1:0]      h_idx_inc;

    assign win_full = (win_fill_reg == WIN_CW'(ONSET_WINDOW));
    assign bt_full  = (bt_fill_reg == BT_CW'(BEAT_TIME_DEPTH));
    assign h_full   = (h_fill_reg == H_CW'(TEMPO_HISTORY_DEPTH));
    assign win_wa   = win_full ? win_head_reg : win_fill_reg[WIN_AW-1:0];
    assign bt_wa    = bt_full ? bt_head_reg : bt_fill_reg[BT_AW-1:0];
    assign h_wa     = h_full ? h_head_reg : h_fill_reg[H_AW-1:0];

    // Ring logical index to physical address
    always_comb
    begin
        bt_log = (cmd.op == OP_IV_FIRST) ? '0 : bt_idx_reg;
        bt_sum = {1'b0, bt_head_reg} + (BT_AW + 1)'(bt_log);
        if (bt_sum >= (BT_AW + 1)'(BEAT_TIME_DEPTH))
            bt_sum = bt_sum - (BT_AW + 1)'(BEAT_TIME_DEPTH);
        bt_ra = bt_sum[BT_AW-1:0];

        h_sum = {1'b0, h_head_reg} + (H_AW + 1)'(h_idx_reg);
        if (h_sum >= (H_AW + 1)'(TEMPO_HISTORY_DEPTH))
            h_sum = h_sum - (H_AW + 1)'(TEMPO_HISTORY_DEPTH);
        h_ra = h_sum[H_AW-1:0];
    end

    // Sorted value list access
    always_comb
    begin
        unique case (cmd.op)
            OP_MED_RD: vals_ra_full = n_reg >> 1;
            OP_MED_LO: vals_ra_full = (n_reg >> 1) - 1'b1;
            default:   vals_ra_full = j_reg - 1'b1;
        endcase
        vals_we = 1'b0;
        vals_wa = j_reg[BT_AW-1:0];
        vals_wd = q_reg;
        if (cmd.op == OP_INS_RD && j_reg == '0)
            vals_we = 1'b1;
        if (cmd.op == OP_INS_CMP)
        begin
            vals_we = 1'b1;
            if (vals_rd_reg > q_reg)
                vals_wd = vals_rd_reg;
        end
    end

    // Threshold, gap and interval tests
    assign rhs       = {2'b00, win_sum_reg} + {1'b0, thrf_reg, 1'b0};
    assign fill_ok   = (win_fill_reg >= WIN_CW'(MIN_ONSET_FILL));
    assign gap_ok    = (now_reg - last_beat_reg) > {16'd0, cfg.min_beat_gap_ms};
    assign beat_det  = fill_ok && ({2'b00, lhs_reg} > rhs) && (v_reg > prev_onset_reg) && gap_ok;
    assign since_inc = since_reg + 4'd1;
    assign iv_ok     = (iv_reg != '0) && (lo_reg <= BPM_NUMERATOR) && (hi_reg >= BPM_NUMERATOR);
    assign med_sum   = {1'b0, mhi_reg} + {1'b0, vals_rd_reg};
    assign med       = n_reg[0] ? mhi_reg : med_sum[TEMPO_W:1];
    assign weight    = WGT_W'(h_idx_reg) + WGT_W'(2);
    assign bt_idx_inc = bt_idx_reg + 1'b1;
    assign h_idx_inc  = h_idx_reg + 1'b1;

    assign sts.beat_det  = beat_det;
    assign sts.est_due   = (since_inc >= cfg.beats_per_update);
    assign sts.bt_enough = (bt_fill_reg != '0);
    assign sts.iv_ok     = iv_ok;
    assign sts.iv_more   = (bt_idx_inc < bt_fill_reg);
    assign sts.j_zero    = (j_reg == '0);
    assign sts.shift_go  = (vals_rd_reg > q_reg);
    assign sts.n_zero    = (n_reg == '0);
    assign sts.hist_more = (h_idx_inc < h_fill_reg);
    assign sts.div_done  = div_done;

    // Divider operand select
    assign div_start    = (cmd.op == OP_IV_CHK && iv_ok) || (cmd.op == OP_AVG_GO);
    assign div_dividend = (cmd.op == OP_AVG_GO) ? acc_reg : BPM_DIVIDEND;
    assign div_divisor  = (cmd.op == OP_AVG_GO) ? wsum_reg : iv_reg;

    ott_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_WIN_UPD)
            win_mem[win_wa] <= v_reg;
        win_rd_reg <= win_mem[win_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_BEAT)
            bt_mem[bt_wa] <= now_reg;
        bt_rd_reg <= bt_mem[bt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vals_we)
            vals_mem[vals_wa] <= vals_wd;
        vals_rd_reg <= vals_mem[vals_ra_full[BT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MED_CALC)
            h_mem[h_wa] <= med;
        h_rd_reg <= h_mem[h_ra];
    end

    // Persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_fill_reg   <= '0;
            win_head_reg   <= '0;
            win_sum_reg    <= '0;
            prev_onset_reg <= '0;
            last_beat_reg  <= '0;
            bt_fill_reg    <= '0;
            bt_head_reg    <= '0;
            since_reg      <= '0;
            h_fill_reg     <= '0;
            h_head_reg     <= '0;
            tempo_reg      <= TEMPO_RESET;
        end
        else
        begin
            unique case (cmd.op)
                OP_WIN_UPD:
                begin
                    win_sum_reg <= win_sum_reg + SUM_W'(v_reg)
                                   - (win_full ? SUM_W'(win_rd_reg) : '0);
                    if (win_full)
                        win_head_reg <= (win_head_reg == WIN_AW'(ONSET_WINDOW - 1))
                                        ? '0 : win_head_reg + 1'b1;
                    else
                        win_fill_reg <= win_fill_reg + 1'b1;
                end
                OP_THR_CMP:
                    if (fill_ok)
                        prev_onset_reg <= v_reg;
                OP_BEAT:
                begin
                    last_beat_reg <= now_reg;
                    since_reg     <= sts.est_due ? 4'd0 : since_inc;
                    if (bt_full)
                        bt_head_reg <= (bt_head_reg == BT_AW'(BEAT_TIME_DEPTH - 1))
                                       ? '0 : bt_head_reg + 1'b1;
                    else
                        bt_fill_reg <= bt_fill_reg + 1'b1;
                end
                OP_MED_CALC:
                    if (h_full)
                        h_head_reg <= (h_head_reg == H_AW'(TEMPO_HISTORY_DEPTH - 1))
                                      ? '0 : h_head_reg + 1'b1;
                    else
                        h_fill_reg <= h_fill_reg + 1'b1;
                OP_AVG_DIV:
                    if (div_done)
                        tempo_reg <= div_quotient[TEMPO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_take)
        begin
            v_reg    <= onset_value;
            now_reg  <= frame_time_ms;
            beat_reg <= 1'b0;
        end
        if (cmd.out_load)
        begin
            out_tempo_reg <= tempo_reg;
            out_beat_reg  <= beat_reg;
        end
        unique case (cmd.op)
            OP_THR_MUL:
            begin
                lhs_reg  <= SUM_W'(v_reg) * SUM_W'(win_fill_reg);
                thrf_reg <= SUM_W'(cfg.onset_threshold) * SUM_W'(win_fill_reg);
            end
            OP_THR_CMP:
                if (beat_det)
                    beat_reg <= 1'b1;
            OP_BEAT:
            begin
                bt_idx_reg <= BT_CW'(1);
                n_reg      <= '0;
            end
            OP_IV_PRV:
                ivprev_reg <= bt_rd_reg;
            OP_IV_SUB:
            begin
                iv_reg     <= bt_rd_reg - ivprev_reg;
                ivprev_reg <= bt_rd_reg;
            end
            OP_IV_MUL:
            begin
                lo_reg <= BPM_PROD_W'(cfg.min_bpm) * BPM_PROD_W'(iv_reg);
                hi_reg <= BPM_PROD_W'(cfg.max_bpm) * BPM_PROD_W'(iv_reg);
            end
            OP_DIV:
                if (div_done)
                begin
                    q_reg <= div_quotient[TEMPO_W-1:0];
                    j_reg <= n_reg;
                end
            OP_INS_RD:
                if (j_reg == '0)
                    n_reg <= n_reg + 1'b1;
            OP_INS_CMP:
                if (vals_rd_reg > q_reg)
                    j_reg <= j_reg - 1'b1;
                else
                    n_reg <= n_reg + 1'b1;
            OP_IV_NEXT:
                bt_idx_reg <= bt_idx_inc;
            OP_MED_LO:
                mhi_reg <= vals_rd_reg;
            OP_MED_CALC:
            begin
                h_idx_reg <= '0;
                acc_reg   <= '0;
                wsum_reg  <= '0;
            end
            OP_HIST_ACC:
            begin
                acc_reg   <= acc_reg + DATA_W'(h_rd_reg) * DATA_W'(weight);
                wsum_reg  <= wsum_reg + DATA_W'(weight);
                h_idx_reg <= h_idx_inc;
            end
            default:
            begin
            end
        endcase
    end

    assign tempo_bpm = out_tempo_reg;
    assign beat      = out_beat_reg;

    `OTT_ASSERT(a_win_fill_bound, win_fill_reg <= WIN_CW'(ONSET_WINDOW),
        "onset window overfilled")
    `OTT_ASSERT(a_sorted_count, (cmd.op != OP_IV_NEXT) || (n_reg < bt_fill_reg),
        "more sorted tempos than intervals")
    `OTT_ASSERT(a_beat_needs_fill, (cmd.op == OP_BEAT) |-> fill_ok,
        "beat with short onset window")

endmodule
